/* rtl/acu_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// acu_pkg - shared types and codes for the alpha compositing unit
// Pixel type, mode register width and Porter-Duff operator codes.
// ---------------------------------------------------------------------------
package acu_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_OVER = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IN   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_OUT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ATOP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_XOR  = 3'd4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

endpackage
`default_nettype wire

/* rtl/acu_pix_in_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// acu_pix_in_if - source/destination pixel pair request channel
// Valid/ready handshake carrying one premultiplied source and destination.
// ---------------------------------------------------------------------------
interface acu_pix_in_if;

    logic                           valid;
    logic                           ready;
    logic [acu_pkg::CHAN_W-1:0]     src_red;
    logic [acu_pkg::CHAN_W-1:0]     src_green;
    logic [acu_pkg::CHAN_W-1:0]     src_blue;
    logic [acu_pkg::CHAN_W-1:0]     src_alpha;
    logic [acu_pkg::CHAN_W-1:0]     dst_red;
    logic [acu_pkg::CHAN_W-1:0]     dst_green;
    logic [acu_pkg::CHAN_W-1:0]     dst_blue;
    logic [acu_pkg::CHAN_W-1:0]     dst_alpha;

    modport source
    (
        output valid,
        input  ready,
        output src_red, src_green, src_blue, src_alpha,
        output dst_red, dst_green, dst_blue, dst_alpha
    );

    modport sink
    (
        input  valid,
        output ready,
        input  src_red, src_green, src_blue, src_alpha,
        input  dst_red, dst_green, dst_blue, dst_alpha
    );

endinterface
`default_nettype wire

/* rtl/acu_pix_out_if.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// acu_pix_out_if - composited pixel request channel
// Valid/ready handshake carrying one composited RGBA pixel.
// ---------------------------------------------------------------------------
interface acu_pix_out_if;

    logic                           valid;
    logic                           ready;
    logic [acu_pkg::CHAN_W-1:0]     out_red;
    logic [acu_pkg::CHAN_W-1:0]     out_green;
    logic [acu_pkg::CHAN_W-1:0]     out_blue;
    logic [acu_pkg::CHAN_W-1:0]     out_alpha;

    modport source
    (
        output valid,
        input  ready,
        output out_red, out_green, out_blue, out_alpha
    );

    modport sink
    (
        input  valid,
        output ready,
        input  out_red, out_green, out_blue, out_alpha
    );

endinterface
`default_nettype wire

/* rtl/acu_blend.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// acu_blend - Porter-Duff blend of one pixel pair
// Two 8x8 products per channel, each divided by 255 with truncation.
// ---------------------------------------------------------------------------
module acu_blend
(
    input  wire logic [acu_pkg::MODE_W-1:0] mode,
    input  wire acu_pkg::rgba_t             src,
    input  wire acu_pkg::rgba_t             dst,
    output acu_pkg::rgba_t                  res
);

    // floor(p/255) for p up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
        return s[15:8];
    endfunction

    // one channel: left term scales the source, right term the destination
    function automatic logic [7:0] blend_chan
    (
        input logic [acu_pkg::MODE_W-1:0] m,
        input logic [7:0]                 s,
        input logic [7:0]                 d,
        input logic [7:0]                 src_k,
        input logic [7:0]                 inv_sa
    );
        logic [7:0] left;
        logic [7:0] right;
        logic [8:0] sum;
        left  = div255({8'd0, s} * {8'd0, src_k});
        right = div255({8'd0, d} * {8'd0, inv_sa});
        case (m)
            acu_pkg::MODE_OVER: sum = {1'b0, s} + {1'b0, right};
            acu_pkg::MODE_IN:   sum = {1'b0, left};
            acu_pkg::MODE_OUT:  sum = {1'b0, left};
            acu_pkg::MODE_ATOP: sum = {1'b0, left} + {1'b0, right};
            acu_pkg::MODE_XOR:  sum = {1'b0, left} + {1'b0, right};
            default:            sum = 9'd0;
        endcase
        return sum[8] ? 8'hFF : sum[7:0];
    endfunction

    logic [7:0] inv_sa;
    logic [7:0] src_k;
    logic [7:0] alpha_blend;

    assign inv_sa = ~src.alpha;
    // in and atop scale the source by dst alpha, the rest by its complement
    assign src_k  = (mode == acu_pkg::MODE_IN || mode == acu_pkg::MODE_ATOP)
                    ? dst.alpha : ~dst.alpha;

    assign alpha_blend = blend_chan(mode, src.alpha, dst.alpha, src_k, inv_sa);

    always_comb
    begin
        res.red   = blend_chan(mode, src.red,   dst.red,   src_k, inv_sa);
        res.green = blend_chan(mode, src.green, dst.green, src_k, inv_sa);
        res.blue  = blend_chan(mode, src.blue,  dst.blue,  src_k, inv_sa);
        res.alpha = (mode == acu_pkg::MODE_ATOP) ? dst.alpha : alpha_blend;
    end

endmodule
`default_nettype wire

/* rtl/alpha_compositing_unit_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// alpha_compositing_unit_top - Porter-Duff compositing of premultiplied RGBA
// Two-stage pipeline: input register, blend logic, result register.
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  -------   ---   ----------------   -------------------------------------
//  pix_in    in    valid / ready      src_{red,green,blue,alpha}, dst_{...}
//  pix_out   out   valid / ready      out_{red,green,blue,alpha}
//  cfg       in    cfg_we             cfg_wdata = mode (over/in/out/atop/xor)
//
//  One pixel per clock sustained while pix_out stays ready. The request lands
//  in the input register at its accept edge, and the blend then moves into
//  the result register, which drives pix_out.
//  Each stage advances whenever it is empty or the stage after it drains,
//  so a stall on pix_out backs up through both stages without a bubble.
//  Reset clears the stage valid flags and sets mode to over.
//
module alpha_compositing_unit_top
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [acu_pkg::MODE_W-1:0]   cfg_wdata,
    acu_pix_in_if.sink                        pix_in,
    acu_pix_out_if.source                     pix_out
);

    // mode register
    logic [acu_pkg::MODE_W-1:0] mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= acu_pkg::MODE_OVER;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    // stage handshakes: a stage may load when empty or when it drains
    logic s1_valid_reg;
    logic s1_valid_next;
    logic s2_valid_reg;
    logic s2_valid_next;
    logic s1_load;
    logic s2_load;

    assign s2_load = !s2_valid_reg || pix_out.ready;
    assign s1_load = !s1_valid_reg || s2_load;

    assign pix_in.ready = s1_load;

    assign s1_valid_next = s1_load ? pix_in.valid : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // input register: capture the request on accept, hold otherwise
    acu_pkg::rgba_t src_reg;
    acu_pkg::rgba_t dst_reg;

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && s1_load)
        begin
            src_reg <= '{pix_in.src_red, pix_in.src_green,
                         pix_in.src_blue, pix_in.src_alpha};
            dst_reg <= '{pix_in.dst_red, pix_in.dst_green,
                         pix_in.dst_blue, pix_in.dst_alpha};
        end
    end

    // blend logic between the two registers
    acu_pkg::rgba_t res_next;

    acu_blend u_blend
    (
        .mode (mode_reg),
        .src  (src_reg),
        .dst  (dst_reg),
        .res  (res_next)
    );

    // result register: load when stage 1 holds a pixel and the slot is free
    acu_pkg::rgba_t res_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_load)
        begin
            res_reg <= res_next;
        end
    end

    assign pix_out.valid     = s2_valid_reg;
    assign pix_out.out_red   = res_reg.red;
    assign pix_out.out_green = res_reg.green;
    assign pix_out.out_blue  = res_reg.blue;
    assign pix_out.out_alpha = res_reg.alpha;

endmodule
`default_nettype wire

/* verif/tb_alpha_compositing_unit_top.sv */
// ---------------------------------------------------------------------------
// tb_alpha_compositing_unit_top - self-checking bench for the compositing unit
// Streams source/destination pixel pairs through every mode code. Each
// composited pixel is checked against an in-bench Porter-Duff predictor.
// Sender and receiver idle at random, and one long receiver stall backs up
// the whole pipeline.
// ---------------------------------------------------------------------------
module tb_alpha_compositing_unit_top;

    // Highest mode code the register can hold. Codes above MODE_XOR are
    // unused and must give transparent black.
    localparam logic [acu_pkg::MODE_W-1:0] MODE_LAST = 3'd7;

    localparam int unsigned PIX_PER_MODE = 30;
    localparam int unsigned STALL_CYCLES = 80;
    localparam int unsigned DRAIN_CYCLES = 4;    // two-stage pipeline plus margin

    typedef struct packed {
        acu_pkg::rgba_t src;
        acu_pkg::rgba_t dst;
    } pix_pair_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we = 1'b0;
    logic [acu_pkg::MODE_W-1:0]     cfg_wdata = '0;

    acu_pix_in_if  pix_in();
    acu_pix_out_if pix_out();

    // Bench copy of the mode register, updated on each config write.
    logic [acu_pkg::MODE_W-1:0]     mode_q = acu_pkg::MODE_OVER;

    pix_pair_t          pending_pix[$];     // requests not yet offered
    acu_pkg::rgba_t     expected_pix[$];    // composited pixels still owed
    pix_pair_t          offer;              // request currently on pix_in

    int unsigned        tx_idle_pct = 0;
    int unsigned        rx_idle_pct = 0;
    logic               rx_hold = 1'b0;
    logic               stall_go = 1'b0;
    int unsigned        err_cnt = 0;

    alpha_compositing_unit_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    always #4 clk = ~clk;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Exact product of a value and an alpha fraction, truncated.
    function automatic int unsigned scale255(input int unsigned x, input int unsigned y);
        return (x * y) / 255;
    endfunction

    function automatic logic [acu_pkg::CHAN_W-1:0] clamp8(input int unsigned v);
        return (v > 255) ? 8'd255 : v[acu_pkg::CHAN_W-1:0];
    endfunction

    // Composite one pixel pair with the given operator.
    function automatic acu_pkg::rgba_t blend_pixel(input logic [acu_pkg::MODE_W-1:0] op,
                                                   input pix_pair_t p);
        int unsigned sc[3];
        int unsigned dc[3];
        int unsigned sa;
        int unsigned da;
        int unsigned v;
        logic [acu_pkg::CHAN_W-1:0] res[3];
        acu_pkg::rgba_t o;
        sc[0] = {24'd0, p.src.red};
        sc[1] = {24'd0, p.src.green};
        sc[2] = {24'd0, p.src.blue};
        dc[0] = {24'd0, p.dst.red};
        dc[1] = {24'd0, p.dst.green};
        dc[2] = {24'd0, p.dst.blue};
        sa = {24'd0, p.src.alpha};
        da = {24'd0, p.dst.alpha};
        for (int k = 0; k < 3; k++)
        begin
            case (op)
                acu_pkg::MODE_OVER: v = sc[k] + scale255(dc[k], 255 - sa);
                acu_pkg::MODE_IN:   v = scale255(sc[k], da);
                acu_pkg::MODE_OUT:  v = scale255(sc[k], 255 - da);
                acu_pkg::MODE_ATOP: v = scale255(sc[k], da) + scale255(dc[k], 255 - sa);
                acu_pkg::MODE_XOR:  v = scale255(sc[k], 255 - da) + scale255(dc[k], 255 - sa);
                default:            v = 0;
            endcase
            res[k] = clamp8(v);
        end
        case (op)
            acu_pkg::MODE_OVER: v = sa + scale255(da, 255 - sa);
            acu_pkg::MODE_IN:   v = scale255(sa, da);
            acu_pkg::MODE_OUT:  v = scale255(sa, 255 - da);
            acu_pkg::MODE_ATOP: v = da;
            acu_pkg::MODE_XOR:  v = scale255(sa, 255 - da) + scale255(da, 255 - sa);
            default:            v = 0;
        endcase
        o.red   = res[0];
        o.green = res[1];
        o.blue  = res[2];
        o.alpha = clamp8(v);
        return o;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Random channel value in 0..hi.
    function automatic logic [acu_pkg::CHAN_W-1:0] rand_upto(input int unsigned hi);
        int unsigned r;
        r = $urandom_range(hi);
        return r[acu_pkg::CHAN_W-1:0];
    endfunction

    // Random pixel: half valid premultiplied (colour <= alpha), some fully
    // random (colour may exceed alpha), some pinned to the range ends (blue 255 or random).
    function automatic acu_pkg::rgba_t rand_pixel();
        acu_pkg::rgba_t p;
        int unsigned kind;
        kind = $urandom_range(9);
        if (kind < 5)
        begin
            p.alpha = rand_upto(255);
            p.red   = rand_upto({24'd0, p.alpha});
            p.green = rand_upto({24'd0, p.alpha});
            p.blue  = rand_upto({24'd0, p.alpha});
        end
        else if (kind < 8)
        begin
            p = $urandom;
        end
        else
        begin
            p.red   = $urandom_range(1) ? 8'd255 : 8'd0;
            p.green = $urandom_range(1) ? 8'd255 : 8'd0;
            p.blue  = $urandom_range(1) ? 8'd255 : rand_upto(255);
            p.alpha = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        return p;
    endfunction

    function automatic acu_pkg::rgba_t flat_pixel(input logic [acu_pkg::CHAN_W-1:0] c,
                                                  input logic [acu_pkg::CHAN_W-1:0] a);
        acu_pkg::rgba_t p;
        p.red   = c;
        p.green = c;
        p.blue  = c;
        p.alpha = a;
        return p;
    endfunction

    // Write the mode register; only called while the pipeline is empty.
    task automatic write_mode(input logic [acu_pkg::MODE_W-1:0] m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mode_q     = m;
    endtask

    // Block until every queued request has been accepted and every result
    // has come back, then let the pipeline settle. Sample on the falling
    // edge so the driver and monitor updates of the rising edge are in.
    task automatic drain_pipe();
        do
            @(negedge clk);
        while (pending_pix.size() != 0 || expected_pix.size() != 0 || pix_in.valid);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Driver: present the next pending request when the channel is free, idling at random.
    // Predict the result at the edge where the request is accepted.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : drive_blk
        pix_pair_t nxt;
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
        end
        else
        begin
            if (pix_in.valid && pix_in.ready)
                expected_pix.push_back(blend_pixel(mode_q, offer));
            // Hold the request until it is taken; otherwise pick what comes next.
            if (!pix_in.valid || pix_in.ready)
            begin
                if (pending_pix.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pending_pix.pop_front();
                    offer            <= nxt;
                    pix_in.valid     <= 1'b1;
                    pix_in.src_red   <= nxt.src.red;
                    pix_in.src_green <= nxt.src.green;
                    pix_in.src_blue  <= nxt.src.blue;
                    pix_in.src_alpha <= nxt.src.alpha;
                    pix_in.dst_red   <= nxt.dst.red;
                    pix_in.dst_green <= nxt.dst.green;
                    pix_in.dst_blue  <= nxt.dst.blue;
                    pix_in.dst_alpha <= nxt.dst.alpha;
                end
                else
                begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Receiver: random back-pressure, forced low during the long stall.
    // -----------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_out.ready <= 1'b0;
        else
            pix_out.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and
    // the pipeline fills up and stalls its input.
    initial
    begin
        wait (stall_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // -----------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : check_blk
        acu_pkg::rgba_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            if (expected_pix.size() == 0)
            begin
                $error("unexpected result: red %0d green %0d blue %0d alpha %0d",
                       pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                       pix_out.out_alpha);
                err_cnt++;
            end
            else
            begin
                want = expected_pix.pop_front();
                if (pix_out.out_red !== want.red)
                begin
                    $error("out_red: expected %0d, got %0d", want.red, pix_out.out_red);
                    err_cnt++;
                end
                if (pix_out.out_green !== want.green)
                begin
                    $error("out_green: expected %0d, got %0d", want.green, pix_out.out_green);
                    err_cnt++;
                end
                if (pix_out.out_blue !== want.blue)
                begin
                    $error("out_blue: expected %0d, got %0d", want.blue, pix_out.out_blue);
                    err_cnt++;
                end
                if (pix_out.out_alpha !== want.alpha)
                begin
                    $error("out_alpha: expected %0d, got %0d", want.alpha, pix_out.out_alpha);
                    err_cnt++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial
    begin : main_seq
        pix_pair_t   pp;
        int unsigned start_mode;
        int unsigned mode_sel;
        logic [acu_pkg::MODE_W-1:0] m;

        // Known values on every input from time zero.
        rst_n            = 1'b0;
        pix_in.valid     = 1'b0;
        pix_in.src_red   = '0;
        pix_in.src_green = '0;
        pix_in.src_blue  = '0;
        pix_in.src_alpha = '0;
        pix_in.dst_red   = '0;
        pix_in.dst_green = '0;
        pix_in.dst_blue  = '0;
        pix_in.dst_alpha = '0;
        pix_out.ready    = 1'b0;
        offer            = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every mode code, including the unused ones, with
        // transparent black, opaque white, and colour far above alpha (which
        // drives the over sum past 255 and into saturation).
        for (int i = acu_pkg::MODE_OVER; i <= MODE_LAST; i++)
        begin
            m = i[acu_pkg::MODE_W-1:0];
            write_mode(m);
            pp.src = flat_pixel(8'd0, 8'd0);
            pp.dst = flat_pixel(8'd0, 8'd0);
            pending_pix.push_back(pp);
            pp.src = flat_pixel(8'd255, 8'd255);
            pp.dst = flat_pixel(8'd255, 8'd255);
            pending_pix.push_back(pp);
            pp.src = flat_pixel(8'd255, 8'd0);
            pp.dst = flat_pixel(8'd255, 8'd0);
            pending_pix.push_back(pp);
            drain_pipe();
        end

        // Random part, three idling regimes: sender lightly idle with a
        // sluggish receiver, then the reverse, then both at full rate.
        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:       begin tx_idle_pct = 14; rx_idle_pct = 55; end
                1:       begin tx_idle_pct = 55; rx_idle_pct = 14; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            start_mode = $urandom_range(MODE_LAST);
            for (int j = 0; j <= MODE_LAST; j++)
            begin
                mode_sel = (start_mode + j) % (MODE_LAST + 1);
                m = mode_sel[acu_pkg::MODE_W-1:0];
                write_mode(m);
                // Kick off the long receiver stall at full sender rate.
                if (regime == 2 && j == 0)
                    stall_go = 1'b1;
                for (int k = 0; k < PIX_PER_MODE; k++)
                begin
                    pp.src = rand_pixel();
                    pp.dst = rand_pixel();
                    pending_pix.push_back(pp);
                end
                drain_pipe();
            end
        end

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
